FILE: rtl/ppeg_pkg.sv
// shared types, constants and the sine table of the pixel effect generator
// no dependencies; imported by ppeg_datapath and the top level

package ppeg_pkg;

	typedef enum logic [2:0] {
		MODE_GRID   = 3'd0,
		MODE_BAR    = 3'd1,
		MODE_RADAR  = 3'd2,
		MODE_IRIS   = 3'd3,
		MODE_GLITCH = 3'd4
	} effect_mode_t;

	// last frame of the iris close animation
	localparam int FRAME_COUNT = 144;

	// center of the half-resolution image
	localparam logic [7:0] CENTER_X = 8'd80;
	localparam logic [6:0] CENTER_Y = 7'd50;

	localparam int IRIS_RADIUS = 90;

	localparam logic [7:0] SWEEP_WIDTH   = 8'd20;
	localparam logic [7:0] SPARKLE_REACH = 8'd40;
	localparam logic [7:0] SPARKLE_LEVEL = 8'd240;
	localparam logic [5:0] SPARKLE_BOOST = 6'd8;
	localparam logic [7:0] GLITCH_LEVEL  = 8'd250;

	// x / 10 == (x * 205) >> 11 for every 8-bit x
	localparam logic [15:0] DIV10_MUL = 16'd205;
	// s / 3 == (s * 683) >> 11 for every s up to 765
	localparam logic [19:0] DIV3_MUL  = 20'd683;

	// handshake-driven load enables, one per pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	typedef logic [255:0][6:0] radius_lut_t;

	// 128 + 127*sin over one full turn
	localparam logic [7:0] SINE_ROM [256] = '{
		8'd128,8'd131,8'd134,8'd137,8'd140,8'd143,8'd146,8'd149,
		8'd152,8'd155,8'd158,8'd162,8'd165,8'd167,8'd170,8'd173,
		8'd176,8'd179,8'd182,8'd185,8'd188,8'd190,8'd193,8'd196,
		8'd198,8'd201,8'd203,8'd206,8'd208,8'd211,8'd213,8'd215,
		8'd218,8'd220,8'd222,8'd224,8'd226,8'd228,8'd230,8'd232,
		8'd234,8'd235,8'd237,8'd238,8'd240,8'd241,8'd243,8'd244,
		8'd245,8'd246,8'd248,8'd249,8'd250,8'd250,8'd251,8'd252,
		8'd253,8'd253,8'd254,8'd254,8'd254,8'd255,8'd255,8'd255,
		8'd255,8'd255,8'd255,8'd255,8'd254,8'd254,8'd254,8'd253,
		8'd253,8'd252,8'd251,8'd250,8'd250,8'd249,8'd248,8'd246,
		8'd245,8'd244,8'd243,8'd241,8'd240,8'd238,8'd237,8'd235,
		8'd234,8'd232,8'd230,8'd228,8'd226,8'd224,8'd222,8'd220,
		8'd218,8'd215,8'd213,8'd211,8'd208,8'd206,8'd203,8'd201,
		8'd198,8'd196,8'd193,8'd190,8'd188,8'd185,8'd182,8'd179,
		8'd176,8'd173,8'd170,8'd167,8'd165,8'd162,8'd158,8'd155,
		8'd152,8'd149,8'd146,8'd143,8'd140,8'd137,8'd134,8'd131,
		8'd128,8'd125,8'd122,8'd119,8'd116,8'd113,8'd110,8'd107,
		8'd104,8'd101,8'd98, 8'd94, 8'd91, 8'd89, 8'd86, 8'd83,
		8'd80, 8'd77, 8'd74, 8'd71, 8'd68, 8'd66, 8'd63, 8'd60,
		8'd58, 8'd55, 8'd53, 8'd50, 8'd48, 8'd45, 8'd43, 8'd41,
		8'd38, 8'd36, 8'd34, 8'd32, 8'd30, 8'd28, 8'd26, 8'd24,
		8'd22, 8'd21, 8'd19, 8'd18, 8'd16, 8'd15, 8'd13, 8'd12,
		8'd11, 8'd10, 8'd8,  8'd7,  8'd6,  8'd6,  8'd5,  8'd4,
		8'd3,  8'd3,  8'd2,  8'd2,  8'd2,  8'd1,  8'd1,  8'd1,
		8'd1,  8'd1,  8'd1,  8'd1,  8'd2,  8'd2,  8'd2,  8'd3,
		8'd3,  8'd4,  8'd5,  8'd6,  8'd6,  8'd7,  8'd8,  8'd10,
		8'd11, 8'd12, 8'd13, 8'd15, 8'd16, 8'd18, 8'd19, 8'd21,
		8'd22, 8'd24, 8'd26, 8'd28, 8'd30, 8'd32, 8'd34, 8'd36,
		8'd38, 8'd41, 8'd43, 8'd45, 8'd48, 8'd50, 8'd53, 8'd55,
		8'd58, 8'd60, 8'd63, 8'd66, 8'd68, 8'd71, 8'd74, 8'd77,
		8'd80, 8'd83, 8'd86, 8'd89, 8'd91, 8'd94, 8'd98, 8'd101,
		8'd104,8'd107,8'd110,8'd113,8'd116,8'd119,8'd122,8'd125
	};

	function automatic logic [7:0] sine_at(input logic [7:0] idx);
		return SINE_ROM[idx];
	endfunction

	// iris radius per frame, floored at one
	function automatic radius_lut_t build_radius_lut();
		radius_lut_t lut;
		int r;
		for (int i = 0; i < 256; i++) begin
			r = IRIS_RADIUS - (i * IRIS_RADIUS) / FRAME_COUNT;
			if (r < 1) begin
				r = 1;
			end
			lut[i] = 7'(r);
		end
		return lut;
	endfunction

	localparam radius_lut_t RADIUS_LUT = build_radius_lut();

endpackage

FILE: rtl/ppeg_ifs.sv
// valid/ready channel interfaces of the pixel effect generator
// no dependencies

interface ppeg_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_x;
	logic [6:0] pixel_y;
	logic [7:0] frame_number;
	logic [7:0] phase_one;
	logic [7:0] phase_two;
	logic [7:0] phase_three;
	logic [7:0] phase_four;

	modport source (
		output valid, pixel_x, pixel_y, frame_number,
		output phase_one, phase_two, phase_three, phase_four,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, frame_number,
		input  phase_one, phase_two, phase_three, phase_four,
		output ready
	);
endinterface

interface ppeg_color_if;
	logic       valid;
	logic       ready;
	logic [7:0] color_index;

	modport source (output valid, color_index, input ready);
	modport sink (input valid, color_index, output ready);
endinterface

FILE: rtl/ppeg_datapath.sv
// five-stage payload pipeline of the pixel effect generator
// depends on ppeg_pkg; stage enables come from the top-level handshake

module ppeg_datapath (
	input  logic                  clk,
	input  ppeg_pkg::stage_en_t   en,
	input  ppeg_pkg::effect_mode_t mode,
	input  logic [7:0]            pixel_x,
	input  logic [6:0]            pixel_y,
	input  logic [7:0]            frame_number,
	input  logic [7:0]            phase_one,
	input  logic [7:0]            phase_two,
	input  logic [7:0]            phase_three,
	input  logic [7:0]            phase_four,
	output logic [7:0]            color_index
);
	import ppeg_pkg::*;

	// stage 1: table addresses, distance, sweep
	logic [7:0]  y8, x3, y5, x7, y13, f3, f7;
	logic [7:0]  ax, oct_dist;
	logic [6:0]  by;
	logic [15:0] xq;
	logic [7:0]  q10;
	logic        line;
	logic [9:0]  isum_addr;
	logic [7:0]  addr_a, addr_b, addr_c, addr_d, addr_e;

	logic [7:0] addr_a_s1, addr_b_s1, addr_c_s1, addr_d_s1, addr_e_s1;
	logic [7:0] x_s1, f_s1, p3_s1, p4_s1, dist_s1, sweep_s1;
	logic [6:0] y_s1, radius_s1;
	logic       line_s1;

	always_comb begin
		y8  = {1'b0, pixel_y};
		x3  = pixel_x + {pixel_x[6:0], 1'b0};
		y5  = y8 + {y8[5:0], 2'b0};
		x7  = {pixel_x[4:0], 3'b0} - pixel_x;
		y13 = {y8[4:0], 3'b0} + {y8[5:0], 2'b0} + y8;
		f3  = {frame_number[6:0], 1'b0} + frame_number;
		f7  = {frame_number[4:0], 3'b0} - frame_number;

		ax = (pixel_x >= CENTER_X) ? pixel_x - CENTER_X : CENTER_X - pixel_x;
		by = (pixel_y >= CENTER_Y) ? pixel_y - CENTER_Y : CENTER_Y - pixel_y;
		if (ax > {1'b0, by}) begin
			oct_dist = ax + {2'b0, by[6:1]};
		end else begin
			oct_dist = {1'b0, by} + {1'b0, ax[7:1]};
		end

		// grid line on every tenth column and every eighth row
		xq   = 16'(pixel_x) * DIV10_MUL;
		q10  = {xq[15:11], 3'b0} + {2'b0, xq[15:11], 1'b0};
		line = (q10 == pixel_x) || (pixel_y[2:0] == 3'b0);

		isum_addr = 10'(pixel_x) + 10'(pixel_y) + 10'(phase_three);

		addr_a = '0;
		addr_b = '0;
		addr_c = '0;
		addr_d = '0;
		addr_e = '0;
		case (mode)
			MODE_GRID: begin
				addr_a = {frame_number[5:0], 2'b0} + phase_two;
				addr_b = x3 + y5 + phase_one;
			end
			MODE_BAR: begin
				addr_a = {pixel_y[4:0], 3'b0} + phase_one;
				addr_b = x3 + phase_two;
				addr_c = {pixel_y[5:0], 2'b0};
			end
			MODE_RADAR: begin
				addr_a = {oct_dist[5:0], 2'b0};
				addr_b = x7 + y13;
			end
			MODE_IRIS: begin
				addr_a = pixel_x + phase_one;
				addr_b = y8 + phase_two;
				addr_c = isum_addr[8:1];
			end
			MODE_GLITCH: begin
				addr_a = pixel_x + phase_one;
				addr_b = y8 + phase_two;
				addr_c = y8 + phase_three;
				addr_d = pixel_x + phase_four;
				addr_e = y8 + f7;
			end
			default: begin
				addr_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			addr_a_s1 <= addr_a;
			addr_b_s1 <= addr_b;
			addr_c_s1 <= addr_c;
			addr_d_s1 <= addr_d;
			addr_e_s1 <= addr_e;
			x_s1      <= pixel_x;
			y_s1      <= pixel_y;
			f_s1      <= frame_number;
			p3_s1     <= phase_three;
			p4_s1     <= phase_four;
			dist_s1   <= oct_dist;
			// (x-80)+(y-50)+128 minus three steps per frame
			sweep_s1  <= pixel_x + y8 + 8'd254 - f3;
			radius_s1 <= RADIUS_LUT[frame_number];
			line_s1   <= line;
		end
	end

	// stage 2: first sine lookups
	logic [7:0] sa_s2, sb_s2, sc_s2, sd_s2, se_s2;
	logic [7:0] x_s2, f_s2, p3_s2, p4_s2, dist_s2, sweep_s2;
	logic [6:0] y_s2, radius_s2;
	logic       line_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sa_s2     <= sine_at(addr_a_s1);
			sb_s2     <= sine_at(addr_b_s1);
			sc_s2     <= sine_at(addr_c_s1);
			sd_s2     <= sine_at(addr_d_s1);
			se_s2     <= sine_at(addr_e_s1);
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			f_s2      <= f_s1;
			p3_s2     <= p3_s1;
			p4_s2     <= p4_s1;
			dist_s2   <= dist_s1;
			sweep_s2  <= sweep_s1;
			radius_s2 <= radius_s1;
			line_s2   <= line_s1;
		end
	end

	// stage 3: grid blend, bar, radar, iris sum, glitch warp addresses
	logic [7:0]  mix, mix_inv, blend_res;
	logic [16:0] blend;
	logic [8:0]  bar_sum;
	logic [9:0]  edge_sum;
	logic [7:0]  edge_sat, bar_res;
	logic [4:0]  bright;
	logic        sparkle;
	logic [5:0]  radar_color;
	logic [8:0]  wx;
	logic [7:0]  wy;
	logic [7:0]  res;

	logic [7:0] res_s3, dist_s3, ga3_s3, ga4_s3;
	logic [9:0] isum_s3;
	logic [6:0] radius_s3;
	logic [8:0] psum_s3;
	logic       flip_s3;

	always_comb begin
		mix       = (f_s2 >= 8'd64) ? 8'hff : {f_s2[5:0], 2'b0};
		mix_inv   = 8'hff - mix;
		// blend toward grey level 128
		blend     = 17'(16'(mix_inv) * 16'(sb_s2)) + 17'({mix, 7'b0});
		blend_res = line_s2 ? sa_s2 : blend[15:8];

		bar_sum  = 9'(sa_s2) + 9'(sb_s2);
		edge_sum = {1'b0, f_s2, 1'b0} + 10'(sc_s2);
		edge_sat = (edge_sum > 10'd255) ? 8'hff : edge_sum[7:0];
		bar_res  = ({x_s2, 1'b0} < {1'b0, edge_sat}) ? 8'd0 : bar_sum[8:1];

		bright      = (sweep_s2 < SWEEP_WIDTH) ? 5'(SWEEP_WIDTH - sweep_s2) : 5'd0;
		sparkle     = (sb_s2 > SPARKLE_LEVEL) && (sweep_s2 < SPARKLE_REACH);
		radar_color = 6'(sa_s2[7:5]) + 6'(bright) + (sparkle ? SPARKLE_BOOST : 6'd0);

		wx = 9'(x_s2) + 9'(sc_s2[7:4]);
		wy = {1'b0, y_s2} + 8'(sd_s2[7:4]);

		case (mode)
			MODE_GRID:  res = blend_res;
			MODE_BAR:   res = bar_res;
			MODE_RADAR: res = {radar_color[4:0], 3'b0};
			default:    res = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			res_s3    <= res;
			isum_s3   <= 10'(sa_s2) + 10'(sb_s2) + 10'(sc_s2);
			dist_s3   <= dist_s2;
			radius_s3 <= radius_s2;
			ga3_s3    <= wx[7:0] + wy + p3_s2;
			ga4_s3    <= {wx[6:0], 1'b0} + p4_s2;
			psum_s3   <= 9'(sa_s2) + 9'(sb_s2);
			flip_s3   <= se_s2 > GLITCH_LEVEL;
		end
	end

	// stage 4: iris average and mask, second glitch lookups
	logic [19:0] iprod;
	logic [7:0]  iris_res;

	logic [7:0] res_s4, v3_s4, v4_s4;
	logic [8:0] psum_s4;
	logic       flip_s4;

	always_comb begin
		iprod    = 20'(isum_s3) * DIV3_MUL;
		iris_res = (dist_s3 > {1'b0, radius_s3}) ? 8'd0 : iprod[18:11];
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			res_s4  <= (mode == MODE_IRIS) ? iris_res : res_s3;
			v3_s4   <= sine_at(ga3_s3);
			v4_s4   <= sine_at(ga4_s3);
			psum_s4 <= psum_s3;
			flip_s4 <= flip_s3;
		end
	end

	// stage 5: glitch average with row inversion, output register
	logic [9:0] gsum;
	logic [7:0] glitch_res;
	logic [7:0] color_s5;

	always_comb begin
		gsum       = 10'(psum_s4) + 10'(v3_s4) + 10'(v4_s4);
		glitch_res = flip_s4 ? ~gsum[9:2] : gsum[9:2];
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			color_s5 <= (mode == MODE_GLITCH) ? glitch_res : res_s4;
		end
	end

	assign color_index = color_s5;

endmodule

FILE: rtl/procedural_pixel_effect_generator_top.sv
// top level of the procedural pixel effect generator: mode register, handshake, valid bits
// depends on ppeg_pkg, ppeg_ifs (channel interfaces) and ppeg_datapath
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+-------------------------------------------------
//   pixel    | in  | valid/ready  | pixel_x, pixel_y, frame_number, phase_one..four
//   color    | out | valid/ready  | color_index
//   cfg      | in  | cfg_we only  | cfg_data = effect_mode (3 bits)
//
// one pixel request per clock while color is not stalled; each result passes through
// the five-stage pipeline: address math, sine rom, mode math,
// second rom pass with the divide by three, output register
// arst_n clears the valid bits and sets the mode to grid; payload registers are not reset
// a stall on color backs up only as far as the first empty stage, so bubbles are squeezed out

module procedural_pixel_effect_generator_top (
	input  logic         clk,
	input  logic         arst_n,
	ppeg_pixel_if.sink   pixel,
	ppeg_color_if.source color,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_data
);
	import ppeg_pkg::*;

	// effect mode; the user must write it only while no request is in flight (not enforced)
	effect_mode_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GRID;
		end else if (cfg_we) begin
			mode_q <= effect_mode_t'(cfg_data);
		end
	end

	// one valid bit per stage, moving with the payload
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	stage_en_t en;

	// a stage can load when it is empty or its contents move on this cycle
	always_comb begin
		en.s5 = !valid_s5 || color.ready;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign pixel.ready = en.s1;
	assign color.valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) begin
				valid_s1 <= pixel.valid;
			end
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.s3) begin
				valid_s3 <= valid_s2;
			end
			if (en.s4) begin
				valid_s4 <= valid_s3;
			end
			if (en.s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// payload stages; the last stage register drives color_index directly
	ppeg_datapath u_datapath (
		.clk          (clk),
		.en           (en),
		.mode         (mode_q),
		.pixel_x      (pixel.pixel_x),
		.pixel_y      (pixel.pixel_y),
		.frame_number (pixel.frame_number),
		.phase_one    (pixel.phase_one),
		.phase_two    (pixel.phase_two),
		.phase_three  (pixel.phase_three),
		.phase_four   (pixel.phase_four),
		.color_index  (color.color_index)
	);

endmodule

FILE: rtl/ppeg_checker.sv
// port-level checks of the pixel effect generator, bound to the top level
// depends on procedural_pixel_effect_generator_top and its channel interfaces

module ppeg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_color
);

	// a held result stays put until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_color))
	else $error("color result changed or dropped while stalled");

	// the block only refuses requests when every stage is full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
	else $error("pixel request refused with room in the pipeline");

	// with no output stall, a request comes out after passing through every stage register
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
		|=> out_valid)
	else $error("color result missing five cycles after request");

endmodule

bind procedural_pixel_effect_generator_top ppeg_checker u_ppeg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (color.valid),
	.out_ready (color.ready),
	.out_color (color.color_index)
);
